// ===== src/mse_pkg.sv =====
// Shared types and constants for the MIPS subset execute block.
package mse_pkg;

	localparam int PROGRAM_DEPTH = 1024;
	localparam int REG_COUNT     = 32;
	localparam int PC_W          = 10;
	localparam int LEN_W         = 11;
	localparam int REG_AW        = 5;

	localparam logic [31:0] SYSCALL_WORD = 32'h0000_000c;

	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_SLTI  = 6'h0a;
	localparam logic [5:0] OPC_ANDI  = 6'h0c;
	localparam logic [5:0] OPC_ORI   = 6'h0d;
	localparam logic [5:0] OPC_LUI   = 6'h0f;
	localparam logic [5:0] OPC_MUL   = 6'h1c;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2a;
	localparam logic [5:0] FN_MUL = 6'h02;

	localparam logic [1:0] STOP_NONE  = 2'd0;
	localparam logic [1:0] STOP_END   = 2'd1;
	localparam logic [1:0] STOP_RANGE = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ADD,
		OP_SUB,
		OP_AND,
		OP_OR,
		OP_SLT,
		OP_MUL,
		OP_BEQ,
		OP_BNE,
		OP_ADDI,
		OP_SLTI,
		OP_ANDI,
		OP_ORI,
		OP_LUI
	} dec_op_t;

endpackage

// ===== src/mse_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== src/mips_subset_execute.sv =====
// Execute stage for a MIPS32 integer subset with register file and instruction index.
// Pipeline: operand read, then execute, each registered, from instruction beat to result beat.
// Throughput: one instruction per cycle while the result side does not stall; register
// file read is registered, the write of the executing instruction is forwarded to the one being read.
// Reset: clears valids, instruction index, program length and register valid bits,
// so every register reads zero until written.
module mips_subset_execute (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [mse_pkg::LEN_W-1:0] program_length,
	input  logic                      instr_valid,
	output logic                      instr_stall,
	input  logic [31:0]               instr_word,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [mse_pkg::PC_W-1:0]  instr_index,
	output logic [mse_pkg::LEN_W-1:0] next_index,
	output logic                      reg_write,
	output logic [4:0]                dest_reg,
	output logic [31:0]               write_value,
	output logic [1:0]                stop_code,
	output logic                      illegal
);

	import mse_pkg::*;

	logic [LEN_W-1:0]  len_q;
	logic [PC_W-1:0]   pc_q;
	logic [REG_COUNT-1:0] rf_vld_q;

	logic              vld_s1;
	logic [31:0]       word_s1;
	logic              fwd_a_s1, fwd_b_s1;
	logic [31:0]       fwd_val_s1;
	logic              rvld_a_s1, rvld_b_s1;

	logic              vld_s2;
	logic [PC_W-1:0]   index_s2;
	logic [LEN_W-1:0]  next_s2;
	logic              wr_s2;
	logic [4:0]        dst_s2;
	logic [31:0]       val_s2;
	logic [1:0]        stop_s2;
	logic              bad_s2;

	logic              accept, exec, out_free;
	logic [31:0]       ram_a, ram_b;
	logic [REG_AW-1:0] rs_in, rt_in;

	logic [5:0]        opc, funct;
	logic [REG_AW-1:0] rs, rt, rd;
	logic [15:0]       imm;
	logic [31:0]       imm_sx, imm_zx;
	logic [31:0]       a, b;
	dec_op_t           op;
	logic              bad;
	logic              wr_raw, wr_en;
	logic [REG_AW-1:0] dst_raw, dst;
	logic [31:0]       val_raw, val;
	logic              taken;
	logic [LEN_W-1:0]  len_eff;
	logic [17:0]       tgt;
	logic [LEN_W-1:0]  next;
	logic [1:0]        stop;

	assign out_free    = !vld_s2 || !result_stall;
	assign exec        = vld_s1 && out_free;
	assign instr_stall = vld_s1 && !out_free;
	assign accept      = instr_valid && !instr_stall;

	assign rs_in = instr_word[25:21];
	assign rt_in = instr_word[20:16];

	mse_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_rf (
		.clk    (clk),
		.we     (exec && wr_en),
		.waddr  (dst),
		.wdata  (val),
		.re     (accept),
		.raddr_a(rs_in),
		.raddr_b(rt_in),
		.rdata_a(ram_a),
		.rdata_b(ram_b)
	);

	// operand fetch
	assign opc    = word_s1[31:26];
	assign rs     = word_s1[25:21];
	assign rt     = word_s1[20:16];
	assign rd     = word_s1[15:11];
	assign funct  = word_s1[5:0];
	assign imm    = word_s1[15:0];
	assign imm_sx = {{16{imm[15]}}, imm};
	assign imm_zx = {16'd0, imm};

	always_comb begin
		if (rs == '0) begin
			a = '0;
		end else if (fwd_a_s1) begin
			a = fwd_val_s1;
		end else if (rvld_a_s1) begin
			a = ram_a;
		end else begin
			a = '0;
		end
		if (rt == '0) begin
			b = '0;
		end else if (fwd_b_s1) begin
			b = fwd_val_s1;
		end else if (rvld_b_s1) begin
			b = ram_b;
		end else begin
			b = '0;
		end
	end

	// decode
	always_comb begin
		op  = OP_NOP;
		bad = 1'b0;
		if (word_s1 == SYSCALL_WORD) begin
			op = OP_NOP;
		end else begin
			unique case (opc)
				OPC_RTYPE: begin
					unique case (funct)
						FN_ADD:  op = OP_ADD;
						FN_SUB:  op = OP_SUB;
						FN_AND:  op = OP_AND;
						FN_OR:   op = OP_OR;
						FN_SLT:  op = OP_SLT;
						default: bad = 1'b1;
					endcase
				end
				OPC_MUL: begin
					if (funct == FN_MUL) begin
						op = OP_MUL;
					end else begin
						bad = 1'b1;
					end
				end
				OPC_BEQ:  op = OP_BEQ;
				OPC_BNE:  op = OP_BNE;
				OPC_ADDI: op = OP_ADDI;
				OPC_SLTI: op = OP_SLTI;
				OPC_ANDI: op = OP_ANDI;
				OPC_ORI:  op = OP_ORI;
				OPC_LUI: begin
					if (rs == '0) begin
						op = OP_LUI;
					end else begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
		end
	end

	// execute
	always_comb begin
		wr_raw  = 1'b0;
		dst_raw = rt;
		val_raw = '0;
		taken   = 1'b0;
		case (op)
			OP_ADD:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = a + b; end
			OP_SUB:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = a - b; end
			OP_AND:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = a & b; end
			OP_OR:   begin wr_raw = 1'b1; dst_raw = rd; val_raw = a | b; end
			OP_SLT:  begin
				wr_raw = 1'b1; dst_raw = rd;
				val_raw = {31'd0, $signed(a) < $signed(b)};
			end
			OP_MUL:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = a * b; end
			OP_BEQ:  taken = (a == b);
			OP_BNE:  taken = (a != b);
			OP_ADDI: begin wr_raw = 1'b1; val_raw = a + imm_sx; end
			OP_SLTI: begin
				wr_raw = 1'b1;
				val_raw = {31'd0, $signed(a) < $signed(imm_sx)};
			end
			OP_ANDI: begin wr_raw = 1'b1; val_raw = a & imm_zx; end
			OP_ORI:  begin wr_raw = 1'b1; val_raw = a | imm_zx; end
			OP_LUI:  begin wr_raw = 1'b1; val_raw = {imm, 16'd0}; end
			default: ;
		endcase
	end

	assign wr_en = wr_raw && (dst_raw != '0);
	assign dst   = wr_en ? dst_raw : '0;
	assign val   = wr_en ? val_raw : '0;

	// next index
	assign len_eff = (len_q > LEN_W'(PROGRAM_DEPTH)) ? LEN_W'(PROGRAM_DEPTH) : len_q;
	assign tgt     = {8'd0, pc_q} + {{2{imm[15]}}, imm};

	always_comb begin
		if (taken) begin
			if (tgt[17] || (tgt[16:0] > {6'd0, len_eff})) begin
				next = '0;
				stop = STOP_RANGE;
			end else begin
				next = tgt[LEN_W-1:0];
				stop = (next >= len_eff) ? STOP_END : STOP_NONE;
			end
		end else begin
			next = {1'b0, pc_q} + LEN_W'(1);
			stop = (next >= len_eff) ? STOP_END : STOP_NONE;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pc_q     <= '0;
			rf_vld_q <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			if (cfg_write) begin
				len_q <= program_length;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (exec) begin
				vld_s1 <= 1'b0;
			end
			if (exec) begin
				vld_s2 <= 1'b1;
				pc_q   <= (stop != STOP_NONE) ? '0 : next[PC_W-1:0];
				if (wr_en) begin
					rf_vld_q[dst] <= 1'b1;
				end
			end else if (!result_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1    <= instr_word;
			fwd_a_s1   <= exec && wr_en && (dst == rs_in);
			fwd_b_s1   <= exec && wr_en && (dst == rt_in);
			fwd_val_s1 <= val;
			rvld_a_s1  <= rf_vld_q[rs_in];
			rvld_b_s1  <= rf_vld_q[rt_in];
		end
		if (exec) begin
			index_s2 <= pc_q;
			next_s2  <= next;
			wr_s2    <= wr_en;
			dst_s2   <= dst;
			val_s2   <= val;
			stop_s2  <= stop;
			bad_s2   <= bad;
		end
	end

	assign result_valid = vld_s2;
	assign instr_index  = index_s2;
	assign next_index   = next_s2;
	assign reg_write    = wr_s2;
	assign dest_reg     = dst_s2;
	assign write_value  = val_s2;
	assign stop_code    = stop_s2;
	assign illegal      = bad_s2;

	a_write_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && reg_write |-> dest_reg != '0)
		else $error("register zero reported as written");

	a_nowrite_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !reg_write |-> dest_reg == '0 && write_value == '0)
		else $error("dropped write carries nonzero fields");

	a_range_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && stop_code == STOP_RANGE |-> next_index == '0)
		else $error("out of range branch with nonzero next index");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		instr_stall |-> result_valid && result_stall)
		else $error("input stalled while result side is free");

	a_stop_restart: assert property (@(posedge clk) disable iff (!arst_n)
		exec && stop != STOP_NONE |=> pc_q == '0)
		else $error("instruction index not restarted after stop");

endmodule

// ===== dv/mips_subset_execute_checker.sv =====
`timescale 1ns / 100ps
// Checker for mips_subset_execute: shadows the register file and instruction index, scores beats.
module mips_subset_execute_checker
	import mse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [LEN_W-1:0]  program_length,
	input  logic              instr_valid,
	input  logic              instr_stall,
	input  logic [31:0]       instr_word,
	input  logic              result_valid,
	input  logic              result_stall,
	input  logic [PC_W-1:0]   instr_index,
	input  logic [LEN_W-1:0]  next_index,
	input  logic              reg_write,
	input  logic [4:0]        dest_reg,
	input  logic [31:0]       write_value,
	input  logic [1:0]        stop_code,
	input  logic              illegal,
	output int unsigned       fail_count,
	output int unsigned       pending
);

	typedef struct packed {
		logic [PC_W-1:0]  idx;
		logic [LEN_W-1:0] nxt;
		logic             wr;
		logic [4:0]       rd;
		logic [31:0]      val;
		logic [1:0]       stop;
		logic             bad;
	} retire_t;

	logic [31:0] gpr [REG_COUNT];
	int          cur_index;
	int          prog_len;
	retire_t     retire_q[$];
	int unsigned mismatches = 0;
	int unsigned outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	function automatic retire_t execute_instr(logic [31:0] w);
		retire_t     r;
		logic [5:0]  opc;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] simm;
		logic [31:0] val;
		logic [4:0]  dst;
		logic        wr;
		logic        bad;
		logic        taken;
		logic [1:0]  stop;
		int          eff_len;
		int          nxt;
		int          target;
		opc   = w[31:26];
		rs    = w[25:21];
		rt    = w[20:16];
		rd    = w[15:11];
		fn    = w[5:0];
		imm   = w[15:0];
		a     = (rs == 5'd0) ? 32'd0 : gpr[rs];
		b     = (rt == 5'd0) ? 32'd0 : gpr[rt];
		simm  = {{16{imm[15]}}, imm};
		wr    = 1'b0;
		bad   = 1'b0;
		taken = 1'b0;
		dst   = 5'd0;
		val   = 32'd0;
		stop  = STOP_NONE;
		eff_len = (prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : prog_len;

		if (w == SYSCALL_WORD) begin
		end else if (opc == OPC_RTYPE) begin
			wr  = 1'b1;
			dst = rd;
			case (fn)
				FN_ADD: val = a + b;
				FN_SUB: val = a - b;
				FN_AND: val = a & b;
				FN_OR:  val = a | b;
				FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
				default: begin
					wr  = 1'b0;
					bad = 1'b1;
				end
			endcase
		end else if (opc == OPC_MUL) begin
			if (fn == FN_MUL) begin
				wr  = 1'b1;
				dst = rd;
				val = a * b;
			end else begin
				bad = 1'b1;
			end
		end else if (opc == OPC_BEQ) begin
			taken = (a == b);
		end else if (opc == OPC_BNE) begin
			taken = (a != b);
		end else if (opc == OPC_ADDI) begin
			wr = 1'b1; dst = rt; val = a + simm;
		end else if (opc == OPC_SLTI) begin
			wr = 1'b1; dst = rt; val = {31'd0, $signed(a) < $signed(simm)};
		end else if (opc == OPC_ANDI) begin
			wr = 1'b1; dst = rt; val = a & {16'd0, imm};
		end else if (opc == OPC_ORI) begin
			wr = 1'b1; dst = rt; val = a | {16'd0, imm};
		end else if (opc == OPC_LUI && rs == 5'd0) begin
			wr = 1'b1; dst = rt; val = {imm, 16'd0};
		end else begin
			bad = 1'b1;
		end

		if (taken) begin
			target = cur_index + int'($signed(imm));
			if (target < 0 || target > eff_len) begin
				stop = STOP_RANGE;
				nxt  = 0;
			end else begin
				nxt = target;
				if (nxt >= eff_len)
					stop = STOP_END;
			end
		end else begin
			nxt = cur_index + 1;
			if (nxt >= eff_len)
				stop = STOP_END;
		end

		if (wr && dst != 5'd0) begin
			gpr[dst] = val;
		end else begin
			wr  = 1'b0;
			dst = 5'd0;
			val = 32'd0;
		end

		r.idx  = cur_index[PC_W-1:0];
		r.nxt  = nxt[LEN_W-1:0];
		r.wr   = wr;
		r.rd   = dst;
		r.val  = val;
		r.stop = stop;
		r.bad  = bad;
		cur_index = (stop != STOP_NONE) ? 0 : int'(nxt[LEN_W-1:0]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		retire_t got;
		retire_t want;
		if (!arst_n) begin
			for (int k = 0; k < REG_COUNT; k++)
				gpr[k] = 32'd0;
			cur_index = 0;
			prog_len  = 0;
			retire_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_write)
				prog_len = int'(program_length);
			if (instr_valid && !instr_stall)
				retire_q.push_back(execute_instr(instr_word));
			if (result_valid && !result_stall) begin
				got = '{instr_index, next_index, reg_write, dest_reg, write_value, stop_code,
					illegal};
				if (retire_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: index %0d", instr_index);
				end else begin
					want = retire_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch index %0d: exp next %0d wr %0b rd %0d val %h ",
								"stop %0d ill %0b | got index %0d next %0d wr %0b rd %0d ",
								"val %h stop %0d ill %0b"},
								want.idx, want.nxt, want.wr, want.rd, want.val, want.stop,
								want.bad, got.idx, got.nxt, got.wr, got.rd, got.val,
								got.stop, got.bad);
					end
				end
			end
			outstanding = retire_q.size();
		end
	end

endmodule

// ===== dv/tb_mips_subset_execute.sv =====
`timescale 1ns / 100ps
// Testbench top for mips_subset_execute: reset, program length phases, instruction stimulus, verdict.
module tb_mips_subset_execute;
	import mse_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [LEN_W-1:0]  program_length;
	logic              instr_valid;
	logic              instr_stall;
	logic [31:0]       instr_word;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [PC_W-1:0]   instr_index;
	logic [LEN_W-1:0]  next_index;
	logic              reg_write;
	logic [4:0]        dest_reg;
	logic [31:0]       write_value;
	logic [1:0]        stop_code;
	logic              illegal;
	logic              calm = 1'b0;
	int unsigned       fail_count;
	int unsigned       pending;

	mips_subset_execute DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.program_length(program_length),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr_word(instr_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.instr_index(instr_index),
		.next_index(next_index),
		.reg_write(reg_write),
		.dest_reg(dest_reg),
		.write_value(write_value),
		.stop_code(stop_code),
		.illegal(illegal)
	);

	mips_subset_execute_checker CHK (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.program_length(program_length),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr_word(instr_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.instr_index(instr_index),
		.next_index(next_index),
		.reg_write(reg_write),
		.dest_reg(dest_reg),
		.write_value(write_value),
		.stop_code(stop_code),
		.illegal(illegal),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 22);
	end

	function automatic logic [31:0] alu_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd, logic [5:0] fn);
		return {opc, rs, rt, rd, 5'($urandom()), fn};
	endfunction

	function automatic logic [31:0] imm_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	// mostly a few hot registers so values feed back into later operands
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(99) < 75) ? 5'($urandom_range(7)) : 5'($urandom());
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'hffff;
			4: return 16'($urandom_range(15));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_offset();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return 16'($urandom());
			default: return 16'($urandom_range(12)) - 16'd6;
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		int          sel;
		dec_op_t     op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [5:0]  fn;
		sel = $urandom_range(99);
		if (sel < 10)
			return $urandom();
		if (sel < 16) begin
			case ($urandom_range(2))
				0: begin
					do
						fn = 6'($urandom());
					while (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR ||
						fn == FN_SLT);
					return alu_word(OPC_RTYPE, pick_reg(), pick_reg(), pick_reg(), fn);
				end
				1: begin
					do
						fn = 6'($urandom());
					while (fn == FN_MUL);
					return alu_word(OPC_MUL, pick_reg(), pick_reg(), pick_reg(), fn);
				end
				default: return imm_word(OPC_LUI, 5'($urandom_range(31, 1)), pick_reg(),
					16'($urandom()));
			endcase
		end
		op = dec_op_t'($urandom_range(OP_LUI));
		rs = pick_reg();
		rt = pick_reg();
		case (op)
			OP_ADD:  return alu_word(OPC_RTYPE, rs, rt, pick_reg(), FN_ADD);
			OP_SUB:  return alu_word(OPC_RTYPE, rs, rt, pick_reg(), FN_SUB);
			OP_AND:  return alu_word(OPC_RTYPE, rs, rt, pick_reg(), FN_AND);
			OP_OR:   return alu_word(OPC_RTYPE, rs, rt, pick_reg(), FN_OR);
			OP_SLT:  return alu_word(OPC_RTYPE, rs, rt, pick_reg(), FN_SLT);
			OP_MUL:  return alu_word(OPC_MUL, rs, rt, pick_reg(), FN_MUL);
			OP_BEQ, OP_BNE: begin
				if ($urandom_range(99) < 30)
					rt = rs;
				return imm_word((op == OP_BEQ) ? OPC_BEQ : OPC_BNE, rs, rt, pick_offset());
			end
			OP_ADDI: return imm_word(OPC_ADDI, rs, rt, pick_imm());
			OP_SLTI: return imm_word(OPC_SLTI, rs, rt, pick_imm());
			OP_ANDI: return imm_word(OPC_ANDI, rs, rt, pick_imm());
			OP_ORI:  return imm_word(OPC_ORI, rs, rt, pick_imm());
			OP_LUI:  return imm_word(OPC_LUI, 5'd0, rt, pick_imm());
			default: return SYSCALL_WORD;
		endcase
	endfunction

	task automatic send_word(input logic [31:0] w);
		while (!calm && $urandom_range(99) < 22) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid <= 1'b1;
		instr_word  <= w;
		@(posedge clk);
		while (instr_stall)
			@(posedge clk);
	endtask

	// step the clock first so the checker has counted the last accepted beat
	task automatic drain();
		instr_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(input int len);
		drain();
		cfg_write      <= 1'b1;
		program_length <= LEN_W'(len);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int lengths[7];
		lengths = '{0, 1, 12, 2047, 40, 1024, 0};
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		program_length = '0;
		instr_valid    = 1'b0;
		instr_word     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		set_length(PROGRAM_DEPTH);
		send_word(imm_word(OPC_LUI, 5'd0, 5'd1, 16'hffff));
		send_word(imm_word(OPC_ORI, 5'd1, 5'd1, 16'hffff));
		send_word(imm_word(OPC_ADDI, 5'd0, 5'd2, 16'h7fff));
		send_word(imm_word(OPC_ADDI, 5'd0, 5'd3, 16'h8000));
		send_word(alu_word(OPC_RTYPE, 5'd1, 5'd2, 5'd4, FN_ADD));
		send_word(alu_word(OPC_RTYPE, 5'd3, 5'd2, 5'd5, FN_SUB));
		send_word(alu_word(OPC_RTYPE, 5'd1, 5'd3, 5'd6, FN_AND));
		send_word(alu_word(OPC_RTYPE, 5'd2, 5'd3, 5'd7, FN_OR));
		send_word(alu_word(OPC_RTYPE, 5'd3, 5'd2, 5'd8, FN_SLT));
		send_word(alu_word(OPC_RTYPE, 5'd2, 5'd3, 5'd9, FN_SLT));
		send_word(alu_word(OPC_MUL, 5'd1, 5'd1, 5'd10, FN_MUL));
		send_word(alu_word(OPC_MUL, 5'd2, 5'd3, 5'd11, FN_MUL));
		send_word(imm_word(OPC_SLTI, 5'd3, 5'd12, 16'h7fff));
		send_word(imm_word(OPC_SLTI, 5'd1, 5'd13, 16'h8000));
		send_word(imm_word(OPC_ANDI, 5'd1, 5'd14, 16'hffff));
		send_word(alu_word(OPC_RTYPE, 5'd1, 5'd2, 5'd0, FN_ADD));
		send_word(imm_word(OPC_ADDI, 5'd0, 5'd0, 16'h1234));
		send_word(SYSCALL_WORD);
		send_word(alu_word(OPC_RTYPE, 5'd1, 5'd2, 5'd3, 6'h3f));
		send_word(alu_word(OPC_MUL, 5'd1, 5'd2, 5'd3, FN_ADD));
		send_word(imm_word(OPC_LUI, 5'd31, 5'd4, 16'h5555));
		send_word(32'hffff_ffff);
		send_word(imm_word(OPC_BEQ, 5'd0, 5'd0, 16'd2));
		send_word(imm_word(OPC_BNE, 5'd1, 5'd2, 16'hffff));
		send_word(imm_word(OPC_BEQ, 5'd0, 5'd0, 16'h8000));
		send_word(imm_word(OPC_BNE, 5'd0, 5'd0, 16'h7fff));
		send_word(imm_word(OPC_BEQ, 5'd0, 5'd0, 16'h7fff));

		lengths[6] = $urandom_range(300, 2);
		for (int ph = 0; ph < 7; ph++) begin
			set_length(lengths[ph]);
			calm = (ph == 5);
			for (int n = 0; n < 180; n++) begin
				if (ph == 2 && n == 90)
					drain();
				send_word(rand_word());
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
